>>> rtl/sobel_edge_magnitude_rgb_unit_defines.svh
`ifndef SOBEL_EDGE_MAGNITUDE_RGB_UNIT_DEFINES_SVH
`define SOBEL_EDGE_MAGNITUDE_RGB_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SEM_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SEM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/sem_pkg.sv
`default_nettype none

package sem_pkg;

    localparam int CHAN_W      = 8;
    localparam int PIXEL_W     = 3 * CHAN_W;
    localparam int GRAD_W      = 11;
    localparam int SUM_W       = 21;
    localparam int CFG_W_W     = 11;
    localparam int CFG_H_W     = 13;
    localparam int CFG_DATA_W  = 13;
    localparam int QUEUE_DEPTH = 4;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int ROOT_STEPS  = 8;

    localparam logic [CHAN_W-1:0]  MAG_MAX      = 8'd255;
    localparam logic [SUM_W-1:0]   SAT_LIMIT    = 21'd65280;
    localparam logic [CFG_W_W-1:0] WIDTH_RESET  = 11'd1024;
    localparam logic [CFG_H_W-1:0] HEIGHT_RESET = 13'd1;

    typedef enum logic [0:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } t_cfg_reg;

    typedef logic [PIXEL_W-1:0] t_pixel;

    typedef struct packed {
        logic                         last;
        logic [2:0][GRAD_W-1:0]       gx;
        logic [2:0][GRAD_W-1:0]       gy;
    } t_grad_item;

    typedef struct packed {
        logic [15:0] s;
        logic [9:0]  rem;
        logic [7:0]  root;
        logic        sat;
    } t_root_lane;

    typedef struct packed {
        logic                  valid;
        logic                  last;
        t_root_lane [2:0]      lane;
    } t_back_stage;

endpackage

`default_nettype wire

>>> rtl/sem_ram.sv
`default_nettype none

module sem_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/sem_queue.sv
`default_nettype none

module sem_queue
    import sem_pkg::*;
#(
    parameter int WIDTH = 67,
    parameter int DEPTH = 4
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_push,
    input  wire logic [WIDTH-1:0]             i_data,
    input  wire logic                         i_pop,
    output logic      [WIDTH-1:0]             o_data,
    output logic      [$clog2(DEPTH+1)-1:0]   o_count
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]    r_count;

    function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_next(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_next(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

`default_nettype wire

>>> rtl/sem_front.sv
`default_nettype none

module sem_front
    import sem_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [CFG_W_W-1:0] i_image_width,
    input  wire logic [CFG_H_W-1:0] i_image_height,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic               i_action,
    input  wire t_pixel             i_pixel,
    input  wire logic [QCNT_W-1:0]  i_q_count,
    output logic                    o_push,
    output t_grad_item              o_item
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int XW = WW + 1;
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 2);
    localparam int WC = (WW > CFG_W_W) ? WW : CFG_W_W;
    localparam int HC = (HW > CFG_H_W) ? HW : CFG_H_W;
    localparam int DW = (RW > WW) ? RW : WW;
    localparam int PW = CW + WW;

    // clamped frame size
    logic [WC-1:0] w_ext;
    logic [HC-1:0] h_ext;
    logic [WW-1:0] wc;
    logic [HW-1:0] hc;

    always_comb begin
        w_ext = WC'(i_image_width);
        h_ext = HC'(i_image_height);
        if (w_ext == '0) begin
            wc = WW'(1);
        end else if (w_ext > WC'(MAX_WIDTH)) begin
            wc = WW'(MAX_WIDTH);
        end else begin
            wc = w_ext[WW-1:0];
        end
        if (h_ext == '0) begin
            hc = HW'(1);
        end else if (h_ext > HC'(MAX_HEIGHT)) begin
            hc = HW'(MAX_HEIGHT);
        end else begin
            hc = h_ext[HW-1:0];
        end
    end

    logic [CW-1:0] r_ic, n_ic;
    logic [RW-1:0] r_ir, n_ir;

    logic          r_s1_valid;
    logic [CW-1:0] r_s1_idx;
    logic          r_s1_use_top, r_s1_use_mid, r_s1_ic_zero, r_s1_ic_one, r_s1_w_ge2;
    logic          r_s1_emit, r_s1_last, r_s1_fwd;
    t_pixel        r_s1_newpx, r_fwd_up, r_fwd_mid;
    t_pixel        r_win [9];

    logic          accept;
    logic [RW-1:0] h_r, h_p1;
    logic [XW-1:0] ic_x, wc_x, ic_inc;
    logic          emit, last, wrap, big;
    logic [RW-1:0] d;
    logic [DW-1:0] d_x;
    logic [PW-1:0] prod;

    assign o_ready = (QCNT_W + 1)'(i_q_count) + (QCNT_W + 1)'(r_s1_valid)
                     < (QCNT_W + 1)'(QUEUE_DEPTH);
    assign accept  = i_valid && o_ready;

    // classify the item against the stream position
    always_comb begin
        h_r    = RW'(hc);
        h_p1   = h_r + 1'b1;
        ic_x   = XW'(r_ic);
        wc_x   = XW'(wc);
        ic_inc = ic_x + 1'b1;
        wrap   = ic_inc >= wc_x;
        emit   = (r_ir >= RW'(2)) || ((r_ir == RW'(1)) && (r_ic != '0))
                 || ((r_ir == '0) && (ic_x > wc_x));
        d      = h_p1 - r_ir;
        d_x    = DW'(d);
        big    = d_x >= DW'(MAX_WIDTH);
        prod   = PW'(d_x[CW-1:0]) * PW'(wc);
        last   = emit && ((r_ir >= h_p1) || (!big && (PW'(r_ic) >= prod)));
        n_ic   = r_ic;
        n_ir   = r_ir;
        if (last) begin
            n_ic = '0;
            n_ir = '0;
        end else if (wrap) begin
            n_ic = '0;
            n_ir = r_ir + 1'b1;
        end else begin
            n_ic = ic_inc[CW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ic       <= '0;
            r_ir       <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
            if (accept) begin
                r_ic <= n_ic;
                r_ir <= n_ir;
            end
        end
    end

    // line store access
    t_pixel ram_up_q, ram_mid_q, up_rd, mid_rd, top_px, mid_px;

    assign up_rd  = r_s1_fwd ? r_fwd_up  : ram_up_q;
    assign mid_rd = r_s1_fwd ? r_fwd_mid : ram_mid_q;
    assign top_px = r_s1_use_top ? up_rd  : '0;
    assign mid_px = r_s1_use_mid ? mid_rd : '0;

    sem_ram #(.WIDTH(PIXEL_W), .DEPTH(MAX_WIDTH)) u_upper (
        .i_clk     (i_clk),
        .i_wr_en   (r_s1_valid),
        .i_wr_addr (r_s1_idx),
        .i_wr_data (mid_rd),
        .i_rd_en   (accept),
        .i_rd_addr (r_ic),
        .o_rd_data (ram_up_q)
    );

    sem_ram #(.WIDTH(PIXEL_W), .DEPTH(MAX_WIDTH)) u_middle (
        .i_clk     (i_clk),
        .i_wr_en   (r_s1_valid),
        .i_wr_addr (r_s1_idx),
        .i_wr_data (r_s1_newpx),
        .i_rd_en   (accept),
        .i_rd_addr (r_ic),
        .o_rd_data (ram_mid_q)
    );

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_idx     <= r_ic;
            r_s1_use_top <= (r_ir >= RW'(2)) && (r_ir <= h_p1);
            r_s1_use_mid <= (r_ir >= RW'(1)) && (r_ir <= h_r);
            r_s1_newpx   <= (!i_action && (r_ir < h_r)) ? i_pixel : '0;
            r_s1_ic_zero <= r_ic == '0;
            r_s1_ic_one  <= r_ic == CW'(1);
            r_s1_w_ge2   <= wc >= WW'(2);
            r_s1_emit    <= emit;
            r_s1_last    <= last;
            r_s1_fwd     <= r_s1_valid && (r_s1_idx == r_ic);
            r_fwd_up     <= mid_rd;
            r_fwd_mid    <= r_s1_newpx;
        end
    end

    // 3x3 window, index col * 3 + row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 9; i++) begin
                r_win[i] <= '0;
            end
        end else if (r_s1_valid) begin
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= r_win[i + 3];
            end
            r_win[6] <= top_px;
            r_win[7] <= mid_px;
            r_win[8] <= r_s1_newpx;
        end
    end

    // gradients per channel
    t_pixel lft [3];
    t_pixel ctr [3];
    t_pixel rgt [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            lft[k] = (r_s1_ic_one || (r_s1_ic_zero && !r_s1_w_ge2)) ? '0 : r_win[3 + k];
            ctr[k] = r_win[6 + k];
        end
        rgt[0] = r_s1_ic_zero ? '0 : top_px;
        rgt[1] = r_s1_ic_zero ? '0 : mid_px;
        rgt[2] = r_s1_ic_zero ? '0 : r_s1_newpx;
    end

    function automatic logic [GRAD_W-1:0] tap_diff(
        input logic [CHAN_W-1:0] a0, input logic [CHAN_W-1:0] a1,
        input logic [CHAN_W-1:0] a2, input logic [CHAN_W-1:0] b0,
        input logic [CHAN_W-1:0] b1, input logic [CHAN_W-1:0] b2
    );
        logic [GRAD_W-1:0] pos, neg;
        pos = GRAD_W'(a0) + GRAD_W'({a1, 1'b0}) + GRAD_W'(a2);
        neg = GRAD_W'(b0) + GRAD_W'({b1, 1'b0}) + GRAD_W'(b2);
        return pos - neg;
    endfunction

    always_comb begin
        o_item.last = r_s1_last;
        for (int c = 0; c < 3; c++) begin
            o_item.gx[c] = tap_diff(
                rgt[0][PIXEL_W-1-CHAN_W*c -: CHAN_W], rgt[1][PIXEL_W-1-CHAN_W*c -: CHAN_W],
                rgt[2][PIXEL_W-1-CHAN_W*c -: CHAN_W], lft[0][PIXEL_W-1-CHAN_W*c -: CHAN_W],
                lft[1][PIXEL_W-1-CHAN_W*c -: CHAN_W], lft[2][PIXEL_W-1-CHAN_W*c -: CHAN_W]);
            o_item.gy[c] = tap_diff(
                lft[2][PIXEL_W-1-CHAN_W*c -: CHAN_W], ctr[2][PIXEL_W-1-CHAN_W*c -: CHAN_W],
                rgt[2][PIXEL_W-1-CHAN_W*c -: CHAN_W], lft[0][PIXEL_W-1-CHAN_W*c -: CHAN_W],
                ctr[0][PIXEL_W-1-CHAN_W*c -: CHAN_W], rgt[0][PIXEL_W-1-CHAN_W*c -: CHAN_W]);
        end
    end

    assign o_push = r_s1_valid && r_s1_emit;

endmodule

`default_nettype wire

>>> rtl/sem_back.sv
`default_nettype none

module sem_back
    import sem_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire t_grad_item        i_item,
    output logic                   o_pop,
    input  wire logic              i_ready,
    output logic                   o_valid,
    output logic                   o_last,
    output logic [CHAN_W-1:0]      o_edge_red,
    output logic [CHAN_W-1:0]      o_edge_green,
    output logic [CHAN_W-1:0]      o_edge_blue
);

    t_back_stage       r_stg [ROOT_STEPS + 1];
    t_back_stage       n_stg0;
    logic              advance;
    logic              r_out_valid, r_out_last;
    logic [CHAN_W-1:0] r_mag [3];

    assign advance = !r_out_valid || i_ready;
    assign o_pop   = advance && i_valid;

    // squares and sum per channel
    always_comb begin
        logic signed [2*GRAD_W-1:0] sq_x, sq_y;
        logic [SUM_W-1:0]           sum;
        n_stg0.valid = o_pop;
        n_stg0.last  = i_item.last;
        for (int c = 0; c < 3; c++) begin
            sq_x = $signed(i_item.gx[c]) * $signed(i_item.gx[c]);
            sq_y = $signed(i_item.gy[c]) * $signed(i_item.gy[c]);
            sum  = sq_x[SUM_W-1:0] + sq_y[SUM_W-1:0];
            n_stg0.lane[c].s    = sum[15:0];
            n_stg0.lane[c].rem  = '0;
            n_stg0.lane[c].root = '0;
            n_stg0.lane[c].sat  = sum > SAT_LIMIT;
        end
    end

    // one root digit per stage
    function automatic t_root_lane root_step(input t_root_lane a);
        logic [11:0] cur, trial;
        t_root_lane  b;
        b     = a;
        cur   = {a.rem, a.s[15:14]};
        trial = {2'b00, a.root, 2'b01};
        b.s   = {a.s[13:0], 2'b00};
        if (cur >= trial) begin
            b.rem  = 10'(cur - trial);
            b.root = {a.root[6:0], 1'b1};
        end else begin
            b.rem  = cur[9:0];
            b.root = {a.root[6:0], 1'b0};
        end
        return b;
    endfunction

    function automatic logic [CHAN_W-1:0] round_mag(input t_root_lane a);
        logic inc;
        inc = a.rem > {2'b00, a.root};
        return a.sat ? MAG_MAX : a.root + CHAN_W'(inc);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= ROOT_STEPS; i++) begin
                r_stg[i] <= '0;
            end
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_stg[0] <= n_stg0;
            for (int i = 1; i <= ROOT_STEPS; i++) begin
                r_stg[i].valid <= r_stg[i-1].valid;
                r_stg[i].last  <= r_stg[i-1].last;
                for (int c = 0; c < 3; c++) begin
                    r_stg[i].lane[c] <= root_step(r_stg[i-1].lane[c]);
                end
            end
            r_out_valid <= r_stg[ROOT_STEPS].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_last <= r_stg[ROOT_STEPS].last;
            for (int c = 0; c < 3; c++) begin
                r_mag[c] <= round_mag(r_stg[ROOT_STEPS].lane[c]);
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_last       = r_out_last;
    assign o_edge_red   = r_mag[0];
    assign o_edge_green = r_mag[1];
    assign o_edge_blue  = r_mag[2];

endmodule

`default_nettype wire

>>> rtl/sobel_edge_magnitude_rgb_unit.sv
// one item per cycle sustained; the front takes an item whenever the gradient queue has room
// the result of stream position q is caused by the item at position q + width + 1
// that result passes the window front stage, the gradient queue, the root pipe and its output register
// synchronous active-low reset clears counters, window, queue and pipe valids
// reset sets width 1024 and height 1; line store contents stay undefined until written
`default_nettype none

`include "sobel_edge_magnitude_rgb_unit_defines.svh"

module sobel_edge_magnitude_rgb_unit
    import sem_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [0:0]            i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wr_data,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [23:0]           s_axis_tdata,   // red, green, blue
    input  wire logic [0:0]            s_axis_tuser,   // action
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [23:0]                m_axis_tdata,   // edge_red, edge_green, edge_blue
    output logic                       m_axis_tlast    // last_pixel
);

    logic [CFG_W_W-1:0] r_image_width;
    logic [CFG_H_W-1:0] r_image_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= WIDTH_RESET;
            r_image_height <= HEIGHT_RESET;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_reg'(i_cfg_addr))
                CFG_IMAGE_WIDTH: begin
                    r_image_width <= i_cfg_wr_data[CFG_W_W-1:0];
                end
                CFG_IMAGE_HEIGHT: begin
                    r_image_height <= i_cfg_wr_data[CFG_H_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    t_pixel             in_px;
    t_grad_item         push_item, pop_item;
    logic               q_push, q_pop;
    logic [QCNT_W-1:0]  q_count;
    logic [CHAN_W-1:0]  edge_r, edge_g, edge_b;

    assign in_px = {s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]};

    sem_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_image_width  (r_image_width),
        .i_image_height (r_image_height),
        .i_valid        (s_axis_tvalid),
        .o_ready        (s_axis_tready),
        .i_action       (s_axis_tuser[0]),
        .i_pixel        (in_px),
        .i_q_count      (q_count),
        .o_push         (q_push),
        .o_item         (push_item)
    );

    sem_queue #(.WIDTH($bits(t_grad_item)), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (push_item),
        .i_pop   (q_pop),
        .o_data  (pop_item),
        .o_count (q_count)
    );

    sem_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (q_count != '0),
        .i_item       (pop_item),
        .o_pop        (q_pop),
        .i_ready      (m_axis_tready),
        .o_valid      (m_axis_tvalid),
        .o_last       (m_axis_tlast),
        .o_edge_red   (edge_r),
        .o_edge_green (edge_g),
        .o_edge_blue  (edge_b)
    );

    assign m_axis_tdata = {edge_b, edge_g, edge_r};

    `SEM_ASSERT_SAME(a_queue_no_overflow, i_clk, i_rst_n, q_push && !q_pop,
        q_count < QCNT_W'(QUEUE_DEPTH), "gradient queue overflow")
    `SEM_ASSERT_SAME(a_queue_no_underflow, i_clk, i_rst_n, q_pop,
        q_count != '0, "gradient queue underflow")
    `SEM_ASSERT_NEXT(a_queue_count_up, i_clk, i_rst_n, q_push && !q_pop,
        q_count == $past(q_count) + 1'b1, "gradient queue count mismatch")

endmodule

`default_nettype wire
